// ===== rtl/core/tbeq_pkg.sv =====
package tbeq_pkg;

  localparam int STATE_SLOTS_DEF = 8;

  localparam int SAMPLE_W   = 24;
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 18;
  localparam int COEF_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int BANDS  = 3;
  localparam int OPA_W  = 34;
  localparam int OPB_W  = 19;
  localparam int PROD_W = 53;
  localparam int ACC_W  = 54;
  localparam int RND_W  = 55;
  localparam int SAT_W  = 56;
  localparam int STEP_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND1_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND2_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND3_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND1_COEF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND2_COEF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAND3_COEF = 3'd6;

  localparam logic [GAIN_W-1:0] GAIN_RST       = 18'd65536;
  localparam logic [COEF_W-1:0] BAND1_COEF_RST = 17'd32768;
  localparam logic [COEF_W-1:0] BAND2_COEF_RST = 17'd4096;
  localparam logic [COEF_W-1:0] BAND3_COEF_RST = 17'd1024;
  localparam logic [COEF_W-1:0] COEF_ONE       = 17'd65536;

  typedef struct packed {
    logic [GAIN_W-1:0] top_gain;
    logic [GAIN_W-1:0] band1_gain;
    logic [GAIN_W-1:0] band2_gain;
    logic [GAIN_W-1:0] band3_gain;
    logic [COEF_W-1:0] band1_coef;
    logic [COEF_W-1:0] band2_coef;
    logic [COEF_W-1:0] band3_coef;
  } cfg_t;

  typedef enum logic [2:0] {
    OPA_DIFF, OPA_U, OPA_MN, OPA_TOP, OPA_B1, OPA_B2, OPA_B3
  } opa_e;

  typedef enum logic [2:0] {
    OPB_F, OPB_OMF, OPB_TG, OPB_G1, OPB_G2, OPB_G3
  } opb_e;

  typedef enum logic [1:0] {WB_SLEW, WB_Y, WB_V} wb_e;

  typedef enum logic [1:0] {JMP_NONE, JMP_BAND, JMP_STAGE, JMP_DONE} jmp_e;

  // slot offset inside a stage
  localparam logic OFF_VAL  = 1'b0;
  localparam logic OFF_SLEW = 1'b1;

  localparam logic [STEP_W-1:0] UC_ENTRY = '0;

  typedef struct packed {
    logic rd;
    logic rd_off;
    logic ld_m;
    logic ld_n;
    logic op_en;
    opa_e opa;
    opb_e opb;
    logic acc_add;
    logic wb_en;
    wb_e  wb;
    jmp_e jmp;
  } ucw_t;

  localparam ucw_t UCW_NOP = '{
    rd: 1'b0, rd_off: OFF_VAL, ld_m: 1'b0, ld_n: 1'b0, op_en: 1'b0,
    opa: OPA_DIFF, opb: OPB_F, acc_add: 1'b0, wb_en: 1'b0, wb: WB_SLEW,
    jmp: JMP_NONE
  };

  function automatic ucw_t uc_mem(input logic rd, input logic off, input logic ldm,
                                  input logic ldn);
    ucw_t w;
    w = UCW_NOP;
    w.rd = rd;
    w.rd_off = off;
    w.ld_m = ldm;
    w.ld_n = ldn;
    return w;
  endfunction

  function automatic ucw_t uc_op(input opa_e a, input opb_e b, input logic add);
    ucw_t w;
    w = UCW_NOP;
    w.op_en = 1'b1;
    w.opa = a;
    w.opb = b;
    w.acc_add = add;
    return w;
  endfunction

  function automatic ucw_t uc_wb(input wb_e dst, input jmp_e j);
    ucw_t w;
    w = UCW_NOP;
    w.wb_en = 1'b1;
    w.wb = dst;
    w.jmp = j;
    return w;
  endfunction

  function automatic ucw_t uc_jmp(input jmp_e j);
    ucw_t w;
    w = UCW_NOP;
    w.jmp = j;
    return w;
  endfunction

  // control store: one section (looped per band), stage combine, output
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    unique case (step)
      5'd0:    w = uc_mem(1'b1, OFF_VAL, 1'b0, 1'b0);
      5'd1:    w = uc_mem(1'b1, OFF_SLEW, 1'b1, 1'b0);
      5'd2:    w = uc_mem(1'b0, OFF_VAL, 1'b0, 1'b1);
      5'd3:    w = uc_op(OPA_DIFF, OPB_F, 1'b0);
      5'd4:    w = uc_op(OPA_U, OPB_F, 1'b0);
      5'd5:    w = uc_op(OPA_MN, OPB_OMF, 1'b1);
      5'd6:    w = uc_wb(WB_SLEW, JMP_NONE);
      5'd7:    w = UCW_NOP;
      5'd8:    w = uc_wb(WB_Y, JMP_BAND);
      5'd9:    w = uc_op(OPA_TOP, OPB_TG, 1'b0);
      5'd10:   w = uc_op(OPA_B1, OPB_G1, 1'b1);
      5'd11:   w = uc_op(OPA_B2, OPB_G2, 1'b1);
      5'd12:   w = uc_op(OPA_B3, OPB_G3, 1'b1);
      5'd13:   w = UCW_NOP;
      5'd14:   w = UCW_NOP;
      5'd15:   w = uc_wb(WB_V, JMP_STAGE);
      5'd16:   w = uc_jmp(JMP_DONE);
      default: w = uc_jmp(JMP_DONE);
    endcase
    return w;
  endfunction

  localparam logic signed [SAT_W-1:0] SAT32_MAX = 56'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT32_MIN = -56'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT32_MAX) begin
      r = SAT32_MAX[DATA_W-1:0];
    end else if (x < SAT32_MIN) begin
      r = SAT32_MIN[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tbeq_in_if.sv =====
interface tbeq_in_if import tbeq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/tbeq_out_if.sv =====
interface tbeq_out_if import tbeq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/tbeq_ram.sv =====
module tbeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/tbeq_seq.sv =====
module tbeq_seq import tbeq_pkg::*; #(
  parameter int STATE_SLOTS = STATE_SLOTS_DEF,
  localparam int STAGES = STATE_SLOTS / 2,
  localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             out_free_i,
  output ucw_t             ucw_o,
  output logic [1:0]       band_o,
  output logic [STG_W-1:0] stage_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam logic [1:0]       LAST_BAND  = 2'(BANDS - 1);
  localparam logic [STG_W-1:0] LAST_STAGE = STG_W'(STAGES - 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        band_q, band_d;
  logic [STG_W-1:0]  stage_q, stage_d;
  ucw_t              word;

  assign word = ucode(step_q);

  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    band_d  = band_q;
    stage_d = stage_q;
    done_o  = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d  = 1'b1;
        step_d  = UC_ENTRY;
        band_d  = '0;
        stage_d = '0;
      end
    end else begin
      unique case (word.jmp)
        JMP_NONE: step_d = step_q + STEP_W'(1);
        JMP_BAND: begin
          if (band_q == LAST_BAND) begin
            band_d = '0;
            step_d = step_q + STEP_W'(1);
          end else begin
            band_d = band_q + 2'd1;
            step_d = UC_ENTRY;
          end
        end
        JMP_STAGE: begin
          if (stage_q == LAST_STAGE) begin
            step_d = step_q + STEP_W'(1);
          end else begin
            stage_d = stage_q + STG_W'(1);
            step_d  = UC_ENTRY;
          end
        end
        JMP_DONE: begin
          // hold here until the output register can take the sample
          if (out_free_i) begin
            busy_d = 1'b0;
            done_o = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= '0;
      band_q  <= '0;
      stage_q <= '0;
    end else begin
      busy_q  <= busy_d;
      step_q  <= step_d;
      band_q  <= band_d;
      stage_q <= stage_d;
    end
  end

  assign ucw_o   = busy_q ? word : UCW_NOP;
  assign band_o  = band_q;
  assign stage_o = stage_q;
  assign busy_o  = busy_q;

endmodule

// ===== rtl/core/tbeq_dp.sv =====
module tbeq_dp import tbeq_pkg::*; #(
  parameter int STATE_SLOTS = STATE_SLOTS_DEF,
  localparam int STAGES = STATE_SLOTS / 2,
  localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  ucw_t                       ucw_i,
  input  logic [1:0]                 band_i,
  input  logic [STG_W-1:0]           stage_i,
  input  logic                       load_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [SAMPLE_W-1:0] result_o
);

  localparam int ADDR_W = $clog2(STATE_SLOTS);
  localparam logic signed [DATA_W:0] OUT_MAX = 33'sd8388607;
  localparam logic signed [DATA_W:0] OUT_MIN = -33'sd8388608;

  logic signed [DATA_W-1:0] v_q, m_q, n_q;
  logic signed [DATA_W-1:0] y_q [BANDS];
  logic signed [OPA_W-1:0]  opa_q, opa;
  logic signed [OPB_W-1:0]  opb_q, opb;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     op_v_q, op_add_q, mul_v_q, mul_add_q;

  logic [DATA_W-1:0]        rdata [BANDS];
  logic [STATE_SLOTS-1:0]   vld_q [BANDS];
  logic                     rd_vld_q;
  logic signed [DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0]        raddr, waddr;
  logic                     ram_we;

  logic signed [DATA_W-1:0] u;
  logic [COEF_W-1:0]        coef, f, omf;
  logic signed [RND_W-1:0]  rnd, shv;
  logic signed [DATA_W-1:0] wb_res;
  logic signed [DATA_W:0]   vr;

  // slot 2s holds the filter value, slot 2s+1 the slew
  assign raddr  = ADDR_W'({stage_i, ucw_i.rd_off});
  assign waddr  = ADDR_W'({stage_i, (ucw_i.wb == WB_SLEW) ? OFF_SLEW : OFF_VAL});
  assign ram_we = ucw_i.wb_en && (ucw_i.wb == WB_SLEW || ucw_i.wb == WB_Y);

  for (genvar k = 0; k < BANDS; k++) begin : g_band
    tbeq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STATE_SLOTS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we && band_i == 2'(k)),
      .waddr_i (waddr),
      .wdata_i (wb_res),
      .re_i    (ucw_i.rd && band_i == 2'(k)),
      .raddr_i (raddr),
      .rdata_o (rdata[k])
    );
  end

  // never-written slots read as zero
  assign rd_data = rd_vld_q ? signed'(rdata[band_i]) : '0;

  always_comb begin
    unique case (band_i)
      2'd0:    u = v_q;
      2'd1:    u = y_q[0];
      default: u = y_q[1];
    endcase
  end

  always_comb begin
    unique case (band_i)
      2'd0:    coef = cfg_i.band1_coef;
      2'd1:    coef = cfg_i.band2_coef;
      default: coef = cfg_i.band3_coef;
    endcase
    f   = (coef > COEF_ONE) ? COEF_ONE : coef;
    omf = COEF_ONE - f;
  end

  always_comb begin
    unique case (ucw_i.opa)
      OPA_DIFF: opa = OPA_W'(u) - OPA_W'(m_q) + OPA_W'(n_q);
      OPA_U:    opa = OPA_W'(u);
      OPA_MN:   opa = OPA_W'(m_q) + OPA_W'(n_q);
      OPA_TOP:  opa = OPA_W'(sat32(SAT_W'(OPA_W'(v_q) - OPA_W'(y_q[0]))));
      OPA_B1:   opa = OPA_W'(sat32(SAT_W'(OPA_W'(y_q[0]) - OPA_W'(y_q[1]))));
      OPA_B2:   opa = OPA_W'(sat32(SAT_W'(OPA_W'(y_q[1]) - OPA_W'(y_q[2]))));
      OPA_B3:   opa = OPA_W'(y_q[2]);
      default:  opa = '0;
    endcase
  end

  always_comb begin
    unique case (ucw_i.opb)
      OPB_F:   opb = signed'({2'b00, f});
      OPB_OMF: opb = signed'({2'b00, omf});
      OPB_TG:  opb = signed'({1'b0, cfg_i.top_gain});
      OPB_G1:  opb = signed'({1'b0, cfg_i.band1_gain});
      OPB_G2:  opb = signed'({1'b0, cfg_i.band2_gain});
      OPB_G3:  opb = signed'({1'b0, cfg_i.band3_gain});
      default: opb = '0;
    endcase
  end

  // round half up: add half an lsb, then arithmetic shift
  always_comb begin
    if (ucw_i.wb == WB_SLEW) begin
      rnd = RND_W'(acc_q) + RND_W'(65536);
      shv = rnd >>> 17;
    end else begin
      rnd = RND_W'(acc_q) + RND_W'(32768);
      shv = rnd >>> 16;
    end
    wb_res = sat32(SAT_W'(shv));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BANDS; k++) begin
        vld_q[k] <= '0;
      end
      rd_vld_q  <= 1'b0;
      op_v_q    <= 1'b0;
      op_add_q  <= 1'b0;
      mul_v_q   <= 1'b0;
      mul_add_q <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_q[band_i][waddr] <= 1'b1;
      end
      if (ucw_i.rd) begin
        rd_vld_q <= vld_q[band_i][raddr];
      end
      op_v_q    <= ucw_i.op_en;
      op_add_q  <= ucw_i.acc_add;
      mul_v_q   <= op_v_q;
      mul_add_q <= op_add_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      v_q <= {{(DATA_W - SAMPLE_W - 1){sample_i[SAMPLE_W-1]}}, sample_i, 1'b0};
    end else if (ucw_i.wb_en && ucw_i.wb == WB_V) begin
      v_q <= wb_res;
    end
    if (ucw_i.wb_en && ucw_i.wb == WB_Y) begin
      y_q[band_i] <= wb_res;
    end
    if (ucw_i.ld_m) begin
      m_q <= rd_data;
    end
    if (ucw_i.ld_n) begin
      n_q <= rd_data;
    end
    if (ucw_i.op_en) begin
      opa_q <= opa;
      opb_q <= opb;
    end
    if (op_v_q) begin
      prod_q <= opa_q * opb_q;
    end
    if (mul_v_q) begin
      acc_q <= (mul_add_q ? acc_q : '0) + ACC_W'(prod_q);
    end
  end

  // Q8.24 back to Q1.23 with rounding and 24-bit saturation
  always_comb begin
    vr = ((DATA_W + 1)'(v_q) + 33'sd1) >>> 1;
    if (vr > OUT_MAX) begin
      result_o = OUT_MAX[SAMPLE_W-1:0];
    end else if (vr < OUT_MIN) begin
      result_o = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      result_o = vr[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/core/three_band_split_eq_filter_unit.sv =====
// channel   dir  beat payload              handshake
// in_i      in   sample_in  s24 Q1.23      valid/ready
// out_o     out  sample_out s24 Q1.23 sat  valid/ready
// cfg       in   cfg_idx_i 3b, cfg_data_i  cfg_we_i, no stall
//
// each sample runs on the single shared multiply-accumulate unit: each
// band section is a nine-step microcode loop, each stage adds a seven-step
// gain combine, then one step hands over the result.
// in_i is ready whenever the sequencer is idle, even while a result waits
// on out_o; the final step holds until the output register is free.
// reset restores the register defaults and clears the per-slot valid bits,
// so all filter state reads as zero with no clearing pass.
module three_band_split_eq_filter_unit import tbeq_pkg::*; #(
  parameter int STATE_SLOTS = STATE_SLOTS_DEF,
  localparam int STAGES = STATE_SLOTS / 2,
  localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tbeq_in_if.sink               in_i,
  tbeq_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_gain   <= GAIN_RST;
      cfg_q.band1_gain <= GAIN_RST;
      cfg_q.band2_gain <= GAIN_RST;
      cfg_q.band3_gain <= GAIN_RST;
      cfg_q.band1_coef <= BAND1_COEF_RST;
      cfg_q.band2_coef <= BAND2_COEF_RST;
      cfg_q.band3_coef <= BAND3_COEF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TOP_GAIN:   cfg_q.top_gain   <= cfg_data_i[GAIN_W-1:0];
        REG_BAND1_GAIN: cfg_q.band1_gain <= cfg_data_i[GAIN_W-1:0];
        REG_BAND2_GAIN: cfg_q.band2_gain <= cfg_data_i[GAIN_W-1:0];
        REG_BAND3_GAIN: cfg_q.band3_gain <= cfg_data_i[GAIN_W-1:0];
        REG_BAND1_COEF: cfg_q.band1_coef <= cfg_data_i[COEF_W-1:0];
        REG_BAND2_COEF: cfg_q.band2_coef <= cfg_data_i[COEF_W-1:0];
        REG_BAND3_COEF: cfg_q.band3_coef <= cfg_data_i[COEF_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // sequencer and datapath
  ucw_t                       ucw;
  logic [1:0]                 band;
  logic [STG_W-1:0]           stage;
  logic                       busy, done, start, out_free;
  logic signed [SAMPLE_W-1:0] result;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;

  assign start     = in_i.valid && in_i.ready;
  assign in_i.ready = !busy;
  assign out_free  = !out_valid_q || out_o.ready;

  tbeq_seq #(
    .STATE_SLOTS (STATE_SLOTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .ucw_o      (ucw),
    .band_o     (band),
    .stage_o    (stage),
    .busy_o     (busy),
    .done_o     (done)
  );

  tbeq_dp #(
    .STATE_SLOTS (STATE_SLOTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ucw_i    (ucw),
    .band_i   (band),
    .stage_i  (stage),
    .load_i   (start),
    .sample_i (in_i.sample_in),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // a taken beat always starts the sequencer
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("sequencer not running after input beat");

  // a result never overwrites one that has not been taken
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (!out_valid_q || out_o.ready))
    else $error("result finished while output register full");

  // finishing frees the sequencer and presents the result
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (out_o.valid && !busy))
    else $error("result not presented after final step");

endmodule

// ===== dv/tb_three_band_split_eq_filter_unit.sv =====
module tb_three_band_split_eq_filter_unit;
  import tbeq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 8;
  localparam int STAGES       = SLOTS / 2;
  // one sample through the sequencer, reckoned from the microcode steps
  localparam int LATENCY      = 34 * STAGES + 1;
  localparam int STALL_LIMIT  = 4000;
  localparam int RAND_PHASES  = 17;
  localparam int PHASE_ITEMS  = 100;
  localparam int DIR_PHASES   = 4;
  localparam int ALL_PHASES   = DIR_PHASES + RAND_PHASES;

  // index with no register behind it, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic [CFG_DATA_W-1:0] GAIN_MAX   = 18'h3FFFF;
  localparam logic [CFG_DATA_W-1:0] GAIN_TWO   = 18'd131072;
  localparam logic [CFG_DATA_W-1:0] COEF_FULL  = 18'h1FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tbeq_in_if  in_if ();
  tbeq_out_if out_if ();

  three_band_split_eq_filter_unit #(
    .STATE_SLOTS(SLOTS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // equalizer model: register mirror and per-stage filter memories
  // ---------------------------------------------------------------------------

  logic [GAIN_W-1:0] top_gain_q, b1_gain_q, b2_gain_q, b3_gain_q;
  logic [COEF_W-1:0] b1_coef_q, b2_coef_q, b3_coef_q;
  // [band][slot]: even slot is the filter value, odd slot the slew
  logic signed [DATA_W-1:0] lp_mem [3][SLOTS];

  function automatic longint clip32(input longint x);
    longint r;
    if (x > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (x < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // add half, then floor: rounds half toward plus infinity
  function automatic longint shift_round(input longint p, input int sh);
    return (p + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // one low-pass section with slew, updates its two slots
  function automatic longint lp_section(input int band, input int slot, input longint coef,
                                        input longint u);
    longint f, m, n, slew, y;
    f = (coef > 65536) ? 65536 : coef;
    m = longint'(lp_mem[band][slot]);
    n = longint'(lp_mem[band][slot+1]);
    slew = clip32(shift_round(((u - m) + n) * f, 17));
    y = clip32(shift_round(f * u + (65536 - f) * (m + n), 16));
    lp_mem[band][slot] = y[DATA_W-1:0];
    lp_mem[band][slot+1] = slew[DATA_W-1:0];
    return y;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] eq_predict(input logic signed [SAMPLE_W-1:0] s);
    longint v, a, b, c, y;
    int st;
    v = longint'(s) * 2;
    for (st = 0; st < STAGES; st++) begin
      a = lp_section(0, 2 * st, longint'(b1_coef_q), v);
      b = lp_section(1, 2 * st, longint'(b2_coef_q), a);
      c = lp_section(2, 2 * st, longint'(b3_coef_q), b);
      v = clip32(v - a);
      a = clip32(a - b);
      b = clip32(b - c);
      v = clip32(shift_round(v * longint'(top_gain_q) + a * longint'(b1_gain_q)
                             + b * longint'(b2_gain_q) + c * longint'(b3_gain_q), 16));
    end
    y = shift_round(v, 1);
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    return y[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queues, counters and handshake pressure
  // ---------------------------------------------------------------------------

  logic signed [SAMPLE_W-1:0] pending_samples[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];

  int  samples_queued = 0;
  int  beats_in       = 0;
  int  beats_out      = 0;
  int  mismatches     = 0;
  int  cfg_sets       = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  quiet_cycles   = 0;
  bit  in_beat        = 1'b0;

  // input driver: holds a beat until taken, then maybe idles before the next one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_beat) begin
      if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.sample_in <= pending_samples.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: check the output beat first, then predict the input beat, so a
  // result never pairs with a sample taken on the same edge
  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] want;
    in_beat <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_out <= beats_out + 1;
      if (expected_samples.size() == 0) begin
        $error("sample_out: result with nothing expected, got %0d", out_if.sample_out);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (out_if.sample_out !== want) begin
          $error("sample_out: expected %0d, got %0d", want, out_if.sample_out);
          mismatches++;
        end
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      beats_in <= beats_in + 1;
      expected_samples.push_back(eq_predict(in_if.sample_in));
    end
  end

  // watchdog on cycles without any beat on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // helpers for the sequence
  // ---------------------------------------------------------------------------

  task automatic add_sample(input logic signed [SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // wait until every queued sample was taken and every result came back
  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (beats_in != samples_queued || expected_samples.size() != 0);
  endtask

  // start a phase: block idle, pick the pressure pattern from the phase number
  task automatic begin_phase(input int ph);
    drain();
    case (ph * 3 / ALL_PHASES)
      0: begin
        send_idle_pct  = 8;
        recv_stall_pct = 53;
      end
      1: begin
        send_idle_pct  = 53;
        recv_stall_pct = 8;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // one register write, the mirror follows the block's decode
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_TOP_GAIN:   top_gain_q = data[GAIN_W-1:0];
      REG_BAND1_GAIN: b1_gain_q  = data[GAIN_W-1:0];
      REG_BAND2_GAIN: b2_gain_q  = data[GAIN_W-1:0];
      REG_BAND3_GAIN: b3_gain_q  = data[GAIN_W-1:0];
      REG_BAND1_COEF: b1_coef_q  = data[COEF_W-1:0];
      REG_BAND2_COEF: b2_coef_q  = data[COEF_W-1:0];
      REG_BAND3_COEF: b3_coef_q  = data[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_eq(input logic [CFG_DATA_W-1:0] tg, input logic [CFG_DATA_W-1:0] g1,
                        input logic [CFG_DATA_W-1:0] g2, input logic [CFG_DATA_W-1:0] g3,
                        input logic [CFG_DATA_W-1:0] c1, input logic [CFG_DATA_W-1:0] c2,
                        input logic [CFG_DATA_W-1:0] c3);
    cfg_write(REG_TOP_GAIN, tg);
    cfg_write(REG_BAND1_GAIN, g1);
    cfg_write(REG_BAND2_GAIN, g2);
    cfg_write(REG_BAND3_GAIN, g3);
    cfg_write(REG_BAND1_COEF, c1);
    cfg_write(REG_BAND2_COEF, c2);
    cfg_write(REG_BAND3_COEF, c3);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  // gains mostly in range, sometimes zero, two or the 18-bit top
  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    logic [CFG_DATA_W-1:0] g;
    case ($urandom_range(0, 7))
      0:       g = '0;
      1:       g = GAIN_MAX;
      2:       g = GAIN_TWO;
      default: g = CFG_DATA_W'($urandom_range(0, 131072));
    endcase
    return g;
  endfunction

  // coefficients mostly below one, sometimes zero, exactly one, or above
  // one with the spare data bit set too
  function automatic logic [CFG_DATA_W-1:0] rand_coef();
    logic [CFG_DATA_W-1:0] c;
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = CFG_DATA_W'(COEF_ONE);
      2:       c = CFG_DATA_W'($urandom_range(65537, 262143));
      default: c = CFG_DATA_W'($urandom_range(0, 65536));
    endcase
    return c;
  endfunction

  // mix of full-scale noise, quiet signal, rails, holds and a random walk
  function automatic logic signed [SAMPLE_W-1:0] rand_sample(
      input logic signed [SAMPLE_W-1:0] prev);
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = SAMPLE_W'($urandom());
      4, 5:       s = SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
      6:          s = SAMPLE_MAX;
      7:          s = SAMPLE_MIN;
      8:          s = prev;
      default:    s = prev + SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic signed [SAMPLE_W-1:0] last;
    int ph;
    int k;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;

    // mirror of the reset state
    top_gain_q = GAIN_RST;
    b1_gain_q  = GAIN_RST;
    b2_gain_q  = GAIN_RST;
    b3_gain_q  = GAIN_RST;
    b1_coef_q  = BAND1_COEF_RST;
    b2_coef_q  = BAND2_COEF_RST;
    b3_coef_q  = BAND3_COEF_RST;
    for (int b = 0; b < 3; b++) begin
      for (int i = 0; i < SLOTS; i++) begin
        lp_mem[b][i] = '0;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: zero, rails held, smallest step either way
    begin_phase(0);
    add_sample('0);
    add_sample(SAMPLE_MAX);
    add_sample(SAMPLE_MAX);
    add_sample(SAMPLE_MIN);
    add_sample(SAMPLE_MIN);
    add_sample(-24'sd1);
    add_sample(24'sd1);

    // junk write to the unused index, then every gain at its top and the
    // coefficients far above one: saturation through every stage
    begin_phase(1);
    cfg_write(REG_NONE, GAIN_MAX);
    set_eq(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, COEF_FULL, COEF_FULL, COEF_FULL);
    add_sample(SAMPLE_MAX);
    add_sample(SAMPLE_MIN);
    add_sample(SAMPLE_MAX);
    add_sample('0);

    // everything zero: sections only coast on their old value and slew
    begin_phase(2);
    set_eq('0, '0, '0, '0, '0, '0, '0);
    add_sample(SAMPLE_MAX);
    add_sample(-24'sd1);
    add_sample('0);

    // mixed gains with a coefficient of exactly one, one near zero and one just below one
    begin_phase(3);
    set_eq('0, GAIN_TWO, 18'd65536, GAIN_MAX, CFG_DATA_W'(COEF_ONE), 18'd1, 18'd65535);
    add_sample(24'sd1);
    add_sample(-24'sd1);
    add_sample(SAMPLE_MIN);
    add_sample(SAMPLE_MAX);
    add_sample(24'sd12345);

    // random settings, each with a block of random samples
    last = '0;
    for (ph = DIR_PHASES; ph < ALL_PHASES; ph++) begin
      begin_phase(ph);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(REG_NONE, CFG_DATA_W'($urandom()));
      end
      set_eq(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
             rand_coef(), rand_coef(), rand_coef());
      for (k = 0; k < PHASE_ITEMS; k++) begin
        last = rand_sample(last);
        add_sample(last);
      end
    end

    drain();
    repeat (LATENCY + 10) @(negedge clk_i);

    $display("equalizer run: %0d samples in, %0d results checked, %0d register settings",
             beats_in, beats_out, cfg_sets);
    $display("pressure patterns: sender gaps, receiver stalls, and none; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
